// ===== hdl/b64d_pkg.sv =====
package b64d_pkg;

	// '=' pad character
	localparam logic [7:0] PAD_CHAR = 8'd61;

	// group queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_LW    = FIFO_AW + 1;

	// byte index inside a group
	localparam logic [1:0] BYTE_HI  = 2'd0;
	localparam logic [1:0] BYTE_MID = 2'd1;
	localparam logic [1:0] BYTE_LO  = 2'd2;

	// one decoded group handed from front to back
	typedef struct packed {
		logic [23:0] bits;
		logic [1:0]  count;  // bytes to send, 1..3
		logic        last;   // final group of the text
	} group_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// sextet lookup: {hit, value}
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [6:0] r;
		r = 7'd0;
		if (c >= 8'd65 && c <= 8'd90) begin
			r = {1'b1, 6'(c - 8'd65)};
		end else if (c >= 8'd97 && c <= 8'd122) begin
			r = {1'b1, 6'(c - 8'd97 + 8'd26)};
		end else if (c >= 8'd48 && c <= 8'd57) begin
			r = {1'b1, 6'(c - 8'd48 + 8'd52)};
		end else if (c == 8'd43) begin
			r = {1'b1, 6'd62};
		end else if (c == 8'd47) begin
			r = {1'b1, 6'd63};
		end
		return r;
	endfunction

endpackage

// ===== hdl/b64d_front.sv =====
module b64d_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           char_in,
	input  logic                 is_last,
	input  b64d_pkg::fifo_stat_t stat,
	output logic                 push,
	output b64d_pkg::group_t     push_data
);

	logic [23:0] bits_q;
	logic [1:0]  pos_q;
	logic [2:0]  pad_q;

	logic [6:0]  sx;
	logic        is_pad;
	logic        accept;
	logic        full_grp;
	logic [23:0] bits_nx;
	logic [2:0]  pad_nx;
	logic [1:0]  count;

	assign in_ready = !stat.full;
	assign accept   = in_valid && in_ready;
	assign sx       = b64d_pkg::sextet_of(char_in);
	assign is_pad   = (char_in == b64d_pkg::PAD_CHAR);
	assign full_grp = (pos_q == 2'd3);

	always_comb begin
		bits_nx = bits_q;
		pad_nx  = 3'd0;
		if (is_pad) begin
			bits_nx = {bits_q[17:0], 6'd0};
			pad_nx  = (pad_q == 3'd7) ? pad_q : pad_q + 3'd1;
		end else if (sx[6]) begin
			bits_nx = {bits_q[17:0], sx[5:0]};
		end
	end

	// trailing pads trim the final group only
	always_comb begin
		count = 2'd3;
		if (is_last) begin
			count = (pad_nx >= 3'd3) ? 2'd0 : 2'(3'd3 - pad_nx);
		end
	end

	assign push           = accept && full_grp && (count != 2'd0);
	assign push_data.bits  = bits_nx;
	assign push_data.count = count;
	assign push_data.last  = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
			pos_q  <= '0;
			pad_q  <= '0;
		end else if (accept) begin
			if (full_grp || is_last) begin
				bits_q <= '0;
				pos_q  <= '0;
				pad_q  <= '0;
			end else begin
				bits_q <= bits_nx;
				pos_q  <= pos_q + 2'd1;
				pad_q  <= pad_nx;
			end
		end
	end

endmodule

// ===== hdl/b64d_fifo.sv =====
module b64d_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  b64d_pkg::group_t     push_data,
	input  logic                 pop,
	output b64d_pkg::group_t     head,
	output b64d_pkg::fifo_stat_t stat
);

	b64d_pkg::group_t                 mem_q [b64d_pkg::FIFO_DEPTH];
	logic [b64d_pkg::FIFO_AW-1:0]     wr_q;
	logic [b64d_pkg::FIFO_AW-1:0]     rd_q;
	logic [b64d_pkg::FIFO_LW-1:0]     level_q;

	assign stat.full  = (level_q == b64d_pkg::FIFO_LW'(b64d_pkg::FIFO_DEPTH));
	assign stat.empty = (level_q == '0);
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.full |-> !push)
		else $error("group queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.empty |-> !pop)
		else $error("group queue read while empty");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= b64d_pkg::FIFO_LW'(b64d_pkg::FIFO_DEPTH))
		else $error("group queue level out of range");

endmodule

// ===== hdl/b64d_back.sv =====
module b64d_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  b64d_pkg::group_t     head,
	input  b64d_pkg::fifo_stat_t stat,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           data_byte,
	output logic                 last_byte
);

	logic [1:0] idx_q;
	logic       vld_q;
	logic [7:0] byte_q;
	logic       last_q;

	logic       load;
	logic       end_grp;
	logic [7:0] sel;

	assign load    = !stat.empty && (!vld_q || out_ready);
	assign end_grp = ((idx_q + 2'd1) == head.count);
	assign pop     = load && end_grp;

	always_comb begin
		unique case (idx_q)
			b64d_pkg::BYTE_HI:  sel = head.bits[23:16];
			b64d_pkg::BYTE_MID: sel = head.bits[15:8];
			b64d_pkg::BYTE_LO:  sel = head.bits[7:0];
			default:            sel = head.bits[7:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			vld_q <= 1'b0;
		end else begin
			if (load) begin
				vld_q <= 1'b1;
				idx_q <= end_grp ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= sel;
			last_q <= head.last && end_grp;
		end
	end

	assign out_valid = vld_q;
	assign data_byte = byte_q;
	assign last_byte = last_q;

endmodule

// ===== hdl/base64_decoder.sv =====
// Channel   Dir  tdata (low bit up)   tlast       tuser
// s_axis    in   char_in[7:0]         is_last     -
// m_axis    out  data_byte[7:0]       last_byte   -
//
// Input side takes one character per cycle while the group queue has room.
// Each fourth character, unless pads leave no bytes, pushes a group of up to
// three bytes into a four-entry queue; the back end sends one byte per cycle
// from it, so the sustained rate is one character per cycle (three bytes per
// four chars). A first byte passes the queue entry and the output register.
// Reset (arst_n low) clears the accumulator, queue pointers and output valid.
// An m_axis stall fills the queue; s_tready drops only when it is full.
module base64_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_in
	input  logic       s_tlast,   // is_last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] data_byte
	output logic       m_tlast    // last_byte
);

	b64d_pkg::group_t     push_data;
	b64d_pkg::group_t     head;
	b64d_pkg::fifo_stat_t stat;
	logic                 push;
	logic                 pop;

	// front: sextet decode, group accumulation, pad trimming
	b64d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.char_in   (s_tdata),
		.is_last   (s_tlast),
		.stat      (stat),
		.push      (push),
		.push_data (push_data)
	);

	// decouples character intake from byte output
	b64d_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (stat)
	);

	// back: serializes each group MSB first into the output register
	b64d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (stat),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.data_byte (m_tdata),
		.last_byte (m_tlast)
	);

endmodule

// ===== bench/b64_stream_checker.sv =====
`timescale 1ns / 100ps

// Watches both stream channels, predicts the decoded bytes and checks them.
module b64_stream_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       s_tlast,
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,
	input  logic       m_tlast,
	output int         fail_count,
	output int         pending,
	output int         bytes_checked,
	output int         texts_flagged
);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} out_byte_t;

	typedef struct packed {
		logic       hit;
		logic [5:0] val;
	} sextet_t;

	out_byte_t   byte_q[$];
	logic [23:0] acc;
	logic [1:0]  pos;
	logic [2:0]  pads;

	function automatic sextet_t char_value(input logic [7:0] c);
		sextet_t r;
		r = '0;
		if (c == "+") begin
			r = '{1'b1, 6'd62};
		end else if (c == "/") begin
			r = '{1'b1, 6'd63};
		end else if (c >= "0" && c <= "9") begin
			r = '{1'b1, 6'(c - "0" + 52)};
		end else if (c >= "A" && c <= "Z") begin
			r = '{1'b1, 6'(c - "A")};
		end else if (c >= "a" && c <= "z") begin
			r = '{1'b1, 6'(c - "a" + 26)};
		end
		return r;
	endfunction

	// One character in; queues the bytes it completes.
	task automatic predict_char(input logic [7:0] c, input logic fin);
		sextet_t   s;
		int        n;
		out_byte_t b;
		s = char_value(c);
		if (c == b64d_pkg::PAD_CHAR) begin
			acc = acc << 6;
			if (pads != 3'd7)
				pads = pads + 3'd1;
		end else begin
			if (s.hit)
				acc = {acc[17:0], s.val};
			pads = '0;   // anything but a pad breaks the trailing run
		end
		if (pos != 2'd3) begin
			pos = pos + 2'd1;
			if (fin) begin
				// partial final group is dropped
				acc = '0;
				pos = '0;
				pads = '0;
			end
			return;
		end
		n = 3;
		if (fin)
			n = (pads >= 3) ? 0 : 3 - int'(pads);
		for (int k = 0; k < n; k++) begin
			b.data_byte = acc[23 - 8*k -: 8];
			b.last_byte = fin && (k == n - 1);
			byte_q.push_back(b);
		end
		acc = '0;
		pos = '0;
		pads = '0;
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		bytes_checked = 0;
		texts_flagged = 0;
		acc = '0;
		pos = '0;
		pads = '0;
	end

	always @(posedge clk) begin
		out_byte_t exp_b;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (byte_q.size() == 0) begin
					$error("unexpected byte: data_byte %h last_byte %b", m_tdata, m_tlast);
					fail_count++;
				end else begin
					exp_b = byte_q.pop_front();
					if (m_tdata !== exp_b.data_byte) begin
						$error("data_byte mismatch: expected %h, actual %h",
							exp_b.data_byte, m_tdata);
						fail_count++;
					end
					if (m_tlast !== exp_b.last_byte) begin
						$error("last_byte mismatch: expected %b, actual %b",
							exp_b.last_byte, m_tlast);
						fail_count++;
					end
					bytes_checked++;
					if (m_tlast === 1'b1)
						texts_flagged++;
				end
			end
			if (s_tvalid && s_tready)
				predict_char(s_tdata, s_tlast);
			pending = byte_q.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;    // [7:0] char_in
	logic       s_tlast;    // is_last
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;    // [7:0] data_byte
	logic       m_tlast;    // last_byte

	int fail_count;
	int pending;
	int bytes_checked;
	int texts_flagged;
	int chars_sent;
	bit steady;             // no idling on either side while set

	base64_decoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	b64_stream_checker u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tlast       (s_tlast),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.fail_count    (fail_count),
		.pending       (pending),
		.bytes_checked (bytes_checked),
		.texts_flagged (texts_flagged)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	// receiver: drops ready about one cycle in five, never while steady
	always @(negedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= 20);
	end

	// sextet value to its alphabet character
	function automatic logic [7:0] alpha_char(input int v);
		if (v < 26)
			return 8'("A" + v);
		else if (v < 52)
			return 8'("a" + v - 26);
		else if (v < 62)
			return 8'("0" + v - 52);
		else if (v == 62)
			return "+";
		return "/";
	endfunction

	// drive one character and hold it until it is taken; returns at a falling edge
	task automatic send_char(input logic [7:0] c, input logic fin);
		while (!steady && $urandom_range(0, 99) < 20) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= fin;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
		chars_sent++;
	endtask

	// whole string, is_last on its final character when fin is set
	task automatic send_str(input string s, input bit fin);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], fin && (i == s.len() - 1));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	// well-formed text: whole groups, trailing pads, rare inner pads and stray characters
	task automatic send_text();
		int          groups;
		int          pad_cnt;
		int          roll;
		logic [7:0]  ch;
		groups = $urandom_range(1, 4);
		pad_cnt = ($urandom_range(0, 99) < 10) ? $urandom_range(3, 4) : $urandom_range(0, 2);
		for (int g = 0; g < groups; g++) begin
			for (int k = 0; k < 4; k++) begin
				roll = $urandom_range(0, 99);
				if (g == groups - 1 && k >= 4 - pad_cnt)
					ch = "=";
				else if (roll < 4)
					ch = 8'($urandom_range(0, 255));
				else if (roll < 7)
					ch = "=";        // pad inside the text, decodes as zeros
				else
					ch = alpha_char($urandom_range(0, 63));
				send_char(ch, (g == groups - 1) && (k == 3));
			end
		end
	endtask

	// noise: any byte, may end early and drop a partial group
	task automatic send_noise();
		int n;
		n = $urandom_range(1, 7);
		for (int i = 0; i < n; i++)
			send_char(8'($urandom_range(0, 255)),
				(i == n - 1) && ($urandom_range(0, 1) == 1));
	endtask

	initial begin
		bit drained;
		drained = 0;
		chars_sent = 0;
		steady = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: every alphabet range, extremes of char_in, pads in an
		// early group, 0/1/2-pad finals, all-pad final, partial final,
		// unknown character breaking the pad run
		send_str("Tm+/", 0);
		send_char(8'h00, 1'b0);
		send_char("=", 1'b0);
		send_char(8'hFF, 1'b0);
		send_char("9", 1'b0);
		send_str("QQ==", 1);
		send_str("QUE=", 1);
		send_str("////", 1);
		send_str("====", 1);
		send_str("Zz0", 1);
		send_str("QU=*", 1);

		// random part
		while (chars_sent < 345) begin
			if (!drained && chars_sent >= 130) begin
				drain();   // hold off until every byte so far has come out
				drained = 1;
			end
			steady = (chars_sent >= 200) && (chars_sent < 290);
			if ($urandom_range(0, 99) < 80)
				send_text();
			else
				send_noise();
		end
		steady = 0;

		drain();
		repeat (16) @(negedge clk);
		$display("summary: %0d characters in, %0d bytes checked, %0d texts closed with last_byte",
			chars_sent, bytes_checked, texts_flagged);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/b64d_pkg.sv
hdl/b64d_front.sv
hdl/b64d_fifo.sv
hdl/b64d_back.sv
hdl/base64_decoder.sv
bench/b64_stream_checker.sv
bench/tb_top.sv
